// ----- hw/rtl/temp_sample_fifo_threshold_alert_assert.svh -----
// assertion macros shared by the temperature sample fifo block
`ifndef TEMP_SAMPLE_FIFO_THRESHOLD_ALERT_ASSERT_SVH
`define TEMP_SAMPLE_FIFO_THRESHOLD_ALERT_ASSERT_SVH
`ifndef SYNTHESIS
// condition must never hold at a clock edge
`define TSFA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tsfa: forbidden condition seen");
// antecedent implies consequent in the same cycle
`define TSFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsfa: implication failed");
`else
`define TSFA_ASSERT_NEVER(lbl, cond)
`define TSFA_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/tsfa_pkg.sv -----
// shared types and constants for the temperature sample fifo block
package tsfa_pkg;

  localparam int unsigned FifoDepth = 16;
  localparam int unsigned AddrW     = $clog2(FifoDepth);
  localparam int unsigned LevelW    = $clog2(FifoDepth + 1);

  localparam logic [15:0] NormBase   = 16'd25000;
  localparam logic [14:0] NormMod    = 15'd10001;
  localparam logic [15:0] NoisyBase  = 16'd20000;
  localparam logic [14:0] NoisyMod   = 15'd20001;
  localparam logic [15:0] RampBase   = 16'd25000;
  localparam logic [14:0] RampWrap   = 15'd20000;
  localparam logic [15:0] EmptyTemp  = 16'd2500;

  // reciprocal remainder: quotient = (word * recip) >> shift, exact for any 32-bit word
  localparam int unsigned NormShift  = 46;
  localparam int unsigned NoisyShift = 47;
  localparam logic [32:0] NormRecip  =
    33'(((65'd1 << NormShift) + 65'(NormMod) - 65'd1) / 65'(NormMod));
  localparam logic [32:0] NoisyRecip =
    33'(((65'd1 << NoisyShift) + 65'(NoisyMod) - 65'd1) / 65'(NoisyMod));

  localparam logic [13:0] IntervalReset  = 14'd1000;
  localparam logic [31:0] ThresholdReset = 32'd27000;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_POLL = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_NOISY  = 2'd1,
    MODE_RAMP   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_INTERVAL  = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_MODE      = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STAT_IDLE       = 3'd0,
    STAT_STORED     = 3'd1,
    STAT_DROPPED    = 3'd2,
    STAT_READ_OK    = 3'd3,
    STAT_READ_EMPTY = 3'd4,
    STAT_POLL       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_CHECK,
    CS_REM,
    CS_COMMIT
  } ctrl_state_t;

  // one fifo entry
  typedef struct packed {
    logic [63:0] ts;
    logic        new_bit;
    logic        crossed;
    logic [15:0] temp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic quot_step;
    logic rem_step;
    logic commit;
  } tsfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_rem;
  } tsfa_sts_t;

endpackage

// ----- hw/rtl/tsfa_rem.sv -----
// remainder of a 32-bit word by the normal or noisy mode divisor
module tsfa_rem (
  input  logic        clk,
  input  logic        quot_en,
  input  logic        rem_en,
  input  logic        noisy,
  input  logic [31:0] x,
  output logic [14:0] rem
);
  import tsfa_pkg::*;

  logic [32:0] recip;
  logic [14:0] divisor;
  logic [64:0] prod;
  logic [18:0] quot_r;
  logic [18:0] quot_nxt;
  logic [31:0] back;
  logic [31:0] diff;
  logic [14:0] rem_r;
  logic [14:0] rem_nxt;

  assign recip   = noisy ? NoisyRecip : NormRecip;
  assign divisor = noisy ? NoisyMod : NormMod;

  // quotient step: quotient by reciprocal multiply
  assign prod     = {33'b0, x} * {32'b0, recip};
  assign quot_nxt = noisy ? {1'b0, prod[NoisyShift +: 18]} : prod[NormShift +: 19];

  // remainder step: word minus quotient times divisor, never above the word
  assign back    = 32'({15'b0, quot_r} * {19'b0, divisor});
  assign diff    = x - back;
  assign rem_nxt = diff[14:0];

  always_ff @(posedge clk) begin
    if (quot_en) begin
      quot_r <= quot_nxt;
    end
    if (rem_en) begin
      rem_r <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule

// ----- hw/rtl/tsfa_ctrl.sv -----
// controller state machine: accept, remainder steps, commit into output register
module tsfa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  tsfa_pkg::tsfa_sts_t   sts,
  output tsfa_pkg::tsfa_cmd_t   cmd
);
  import tsfa_pkg::*;

  ctrl_state_t          state_r;
  ctrl_state_t          state_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_CHECK;
      end
      CS_CHECK: begin
        state_nxt = sts.need_rem ? CS_REM : CS_COMMIT;
      end
      CS_REM: begin
        state_nxt = CS_COMMIT;
      end
      CS_COMMIT: begin
        if (out_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state_r != CS_IDLE);
    cmd.load      = (state_r == CS_IDLE) && in_valid;
    cmd.quot_step = (state_r == CS_CHECK);
    cmd.rem_step  = (state_r == CS_REM);
    cmd.commit    = (state_r == CS_COMMIT) && out_free;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/tsfa_datapath.sv -----
// datapath: config registers, sample generation, threshold logic, fifo and result registers
module tsfa_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tsfa_pkg::tsfa_cmd_t   cmd,
  output tsfa_pkg::tsfa_sts_t   sts,
  input  logic [1:0]            in_func,
  input  logic [31:0]           in_random_word,
  input  logic [63:0]           in_time_ns,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_wdata,
  output logic [2:0]            out_status,
  output logic [15:0]           out_temp_mc,
  output logic [63:0]           out_sample_time,
  output logic                  out_crossed_bit,
  output logic                  out_new_sample_bit,
  output logic                  out_data_ready,
  output logic                  out_alert_seen,
  output logic                  out_below_threshold,
  output logic [4:0]            out_fifo_level,
  output logic [63:0]           out_samples_total,
  output logic [63:0]           out_alerts_total,
  output logic [15:0]           out_latest_temp
);
  import tsfa_pkg::*;

  // latched item
  logic [1:0]  func_r;
  logic [31:0] rnd_r;
  logic [63:0] tns_r;

  // configuration
  logic [13:0] interval_r;
  logic [31:0] thr_r;
  logic [1:0]  mode_r;

  // state
  logic [13:0]       cd_r, cd_nxt;
  logic [AddrW-1:0]  wp_r, wp_nxt;
  logic [AddrW-1:0]  rp_r, rp_nxt;
  logic [LevelW-1:0] level_r, level_nxt;
  logic              below_r, below_nxt;
  logic              alert_r, alert_nxt;
  logic [63:0]       stored_r, stored_nxt;
  logic [63:0]       alerts_r, alerts_nxt;
  logic [14:0]       ramp_r, ramp_nxt;
  logic [15:0]       latest_r, latest_nxt;

  entry_t mem [FifoDepth];
  entry_t rd_r;
  entry_t wr_entry;
  logic   push;

  // result values
  logic [2:0]  o_status;
  logic [15:0] o_temp;
  logic [63:0] o_time;
  logic        o_crossed;
  logic        o_new;
  logic        o_seen;

  // result registers
  logic [2:0]  status_r;
  logic [15:0] temp_r;
  logic [63:0] time_r;
  logic        crossed_r;
  logic        new_r;
  logic        ready_r;
  logic        seen_r;
  logic        below_out_r;
  logic [4:0]  level_out_r;
  logic [63:0] stored_out_r;
  logic [63:0] alerts_out_r;
  logic [15:0] latest_out_r;

  logic [13:0] cd_inc;
  logic        due;
  logic        full;
  logic        noisy;
  logic [14:0] rem;
  logic [15:0] temp_gen;
  logic        below_hit;

  assign cd_inc  = cd_r + 14'd1;
  assign due     = (func_r == FUNC_TICK) && (cd_inc >= interval_r);
  assign full    = (level_r == LevelW'(FifoDepth));
  assign noisy   = (mode_r == MODE_NOISY);
  assign sts.need_rem = due && (mode_r != MODE_RAMP);

  tsfa_rem u_rem (
    .clk     (clk),
    .quot_en (cmd.quot_step),
    .rem_en  (cmd.rem_step),
    .noisy   (noisy),
    .x       (rnd_r),
    .rem     (rem)
  );

  always_comb begin
    unique case (mode_r)
      MODE_NOISY: temp_gen = NoisyBase + {1'b0, rem};
      MODE_RAMP:  temp_gen = RampBase + {1'b0, ramp_r};
      default:    temp_gen = NormBase + {1'b0, rem};
    endcase
  end

  // sample is positive, threshold is signed
  assign below_hit = $signed({17'b0, temp_gen}) <= $signed({thr_r[31], thr_r});

  always_comb begin
    cd_nxt     = cd_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    level_nxt  = level_r;
    below_nxt  = below_r;
    alert_nxt  = alert_r;
    stored_nxt = stored_r;
    alerts_nxt = alerts_r;
    ramp_nxt   = ramp_r;
    latest_nxt = latest_r;
    push       = 1'b0;
    o_status   = STAT_IDLE;
    o_temp     = '0;
    o_time     = '0;
    o_crossed  = 1'b0;
    o_new      = 1'b0;
    unique case (func_r)
      FUNC_TICK: begin
        cd_nxt = cd_inc;
        if (due) begin
          cd_nxt = '0;
          if (below_hit) begin
            below_nxt = 1'b1;
            if (!below_r) begin
              alert_nxt  = 1'b1;
              o_crossed  = 1'b1;
              alerts_nxt = alerts_r + 64'd1;
            end
          end else begin
            below_nxt = 1'b0;
          end
          o_temp = temp_gen;
          o_time = tns_r;
          o_new  = 1'b1;
          if (!full) begin
            push       = 1'b1;
            wp_nxt     = (wp_r == AddrW'(FifoDepth - 1)) ? '0 : wp_r + AddrW'(1);
            level_nxt  = level_r + LevelW'(1);
            stored_nxt = stored_r + 64'd1;
            ramp_nxt   = (ramp_r == RampWrap - 15'd1) ? '0 : ramp_r + 15'd1;
            latest_nxt = temp_gen;
            o_status   = STAT_STORED;
          end else begin
            o_status = STAT_DROPPED;
          end
        end
      end
      FUNC_READ: begin
        if (level_r != '0) begin
          o_temp    = rd_r.temp;
          o_time    = rd_r.ts;
          o_crossed = rd_r.crossed;
          o_new     = rd_r.new_bit;
          rp_nxt    = (rp_r == AddrW'(FifoDepth - 1)) ? '0 : rp_r + AddrW'(1);
          level_nxt = level_r - LevelW'(1);
          o_status  = STAT_READ_OK;
        end else begin
          o_status = STAT_READ_EMPTY;
        end
      end
      FUNC_POLL: begin
        alert_nxt = 1'b0;
        o_status  = STAT_POLL;
      end
      default: ;
    endcase
    // a poll reports the alert it clears
    o_seen = (func_r == FUNC_POLL) ? alert_r : alert_nxt;
  end

  assign wr_entry = '{ts: tns_r, new_bit: 1'b1, crossed: o_crossed, temp: temp_gen};

  always_ff @(posedge clk) begin
    if (cmd.commit && push) begin
      mem[wp_r] <= wr_entry;
    end
    rd_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      rnd_r  <= in_random_word;
      tns_r  <= in_time_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= IntervalReset;
      thr_r      <= ThresholdReset;
      mode_r     <= MODE_NORMAL;
      cd_r       <= '0;
      wp_r       <= '0;
      rp_r       <= '0;
      level_r    <= '0;
      below_r    <= 1'b0;
      alert_r    <= 1'b0;
      stored_r   <= '0;
      alerts_r   <= '0;
      ramp_r     <= '0;
    end else begin
      if (cmd.commit) begin
        cd_r     <= cd_nxt;
        wp_r     <= wp_nxt;
        rp_r     <= rp_nxt;
        level_r  <= level_nxt;
        below_r  <= below_nxt;
        alert_r  <= alert_nxt;
        stored_r <= stored_nxt;
        alerts_r <= alerts_nxt;
        ramp_r   <= ramp_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INTERVAL: begin
            interval_r <= cfg_wdata[13:0];
            cd_r       <= '0;
          end
          CFG_THRESHOLD: thr_r  <= cfg_wdata;
          CFG_MODE:      mode_r <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      latest_r     <= latest_nxt;
      status_r     <= o_status;
      temp_r       <= o_temp;
      time_r       <= o_time;
      crossed_r    <= o_crossed;
      new_r        <= o_new;
      ready_r      <= (level_nxt != '0);
      seen_r       <= o_seen;
      below_out_r  <= below_nxt;
      level_out_r  <= 5'(level_nxt);
      stored_out_r <= stored_nxt;
      alerts_out_r <= alerts_nxt;
      latest_out_r <= (level_nxt != '0) ? latest_nxt : EmptyTemp;
    end
  end

  assign out_status          = status_r;
  assign out_temp_mc         = temp_r;
  assign out_sample_time     = time_r;
  assign out_crossed_bit     = crossed_r;
  assign out_new_sample_bit  = new_r;
  assign out_data_ready      = ready_r;
  assign out_alert_seen      = seen_r;
  assign out_below_threshold = below_out_r;
  assign out_fifo_level      = level_out_r;
  assign out_samples_total   = stored_out_r;
  assign out_alerts_total    = alerts_out_r;
  assign out_latest_temp     = latest_out_r;

endmodule

// ----- hw/rtl/temp_sample_fifo_threshold_alert.sv -----
// top level of the simulated temperature sensor with sample fifo and low-threshold alert
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   func, random_word, time_ns
//   out_     output     out_valid / out_stall status, sample, fifo and counter fields
//   cfg_     input      cfg_valid / cfg_ready index (0 interval, 1 threshold, 2 mode), wdata
//
// an item holds the block through accept, decode and commit; the result
//   register loads as the item leaves commit
// a tick that generates a random-mode sample adds a rem state: decode forms the
//   quotient by reciprocal multiply, the rem state subtracts quotient times divisor
// a result waits in the output register under out_stall; the next item is taken
//   meanwhile and holds in commit until that register frees up
// rst_n is synchronous; no clearing pass, the fifo memory is only read where written
`include "temp_sample_fifo_threshold_alert_assert.svh"
module temp_sample_fifo_threshold_alert (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_random_word,
  input  logic [63:0] in_time_ns,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_temp_mc,
  output logic [63:0] out_sample_time,
  output logic        out_crossed_bit,
  output logic        out_new_sample_bit,
  output logic        out_data_ready,
  output logic        out_alert_seen,
  output logic        out_below_threshold,
  output logic [4:0]  out_fifo_level,
  output logic [63:0] out_samples_total,
  output logic [63:0] out_alerts_total,
  output logic [15:0] out_latest_temp,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import tsfa_pkg::*;

  tsfa_cmd_t ctl_cmd;
  tsfa_sts_t dp_sts;
  logic      cross_sample;

  // config registers sit in flops, so every write lands at once
  assign cfg_ready = 1'b1;

  // sequencing: accept, optional remainder steps, commit
  tsfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  // generation, threshold latch, fifo, counters and result registers
  tsfa_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (ctl_cmd),
    .sts                 (dp_sts),
    .in_func             (in_func),
    .in_random_word      (in_random_word),
    .in_time_ns          (in_time_ns),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_status          (out_status),
    .out_temp_mc         (out_temp_mc),
    .out_sample_time     (out_sample_time),
    .out_crossed_bit     (out_crossed_bit),
    .out_new_sample_bit  (out_new_sample_bit),
    .out_data_ready      (out_data_ready),
    .out_alert_seen      (out_alert_seen),
    .out_below_threshold (out_below_threshold),
    .out_fifo_level      (out_fifo_level),
    .out_samples_total   (out_samples_total),
    .out_alerts_total    (out_alerts_total),
    .out_latest_temp     (out_latest_temp)
  );

  // a freshly generated sample that caused a crossing
  assign cross_sample = out_valid && out_crossed_bit &&
                        (out_status == STAT_STORED || out_status == STAT_DROPPED);

  // fifo level never exceeds its depth
  `TSFA_ASSERT_NEVER(a_level_bound, out_valid && (out_fifo_level > 5'(FifoDepth)))
  // ready flag tracks the reported level
  `TSFA_ASSERT_IMPL(a_ready_level, out_valid, out_data_ready == (out_fifo_level != 5'd0))
  // a crossing sample latches below-threshold and raises the alert
  `TSFA_ASSERT_IMPL(a_cross_alert, cross_sample, out_below_threshold && out_alert_seen)
  // every popped entry was written with its new-sample mark
  `TSFA_ASSERT_IMPL(a_pop_marked, out_valid && (out_status == STAT_READ_OK), out_new_sample_bit)

endmodule
